// File: rtl/dated_rate_floor_lookup_macros.svh
// assertion macros for the dated rate floor lookup
`ifndef DATED_RATE_FLOOR_LOOKUP_MACROS_SVH
`define DATED_RATE_FLOOR_LOOKUP_MACROS_SVH

// same-cycle implication, checked outside reset
`define DRFL_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DRFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/drfl_pkg.sv
// shared types, constants and helpers for the dated rate floor lookup
`default_nettype none

package drfl_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int FRACTION_BITS = 16;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 7;
    localparam int DAY_W    = 7;
    localparam int KEY_W    = 23;
    localparam int PRICE_W  = 40;
    localparam int AMOUNT_W = 32;
    localparam int LIMIT_W  = 31;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 50;

    // price is split into a 32-bit low part and an upper part for the product
    localparam int PLO_W    = 32 + LIMIT_W;
    localparam int PHI_IN_W = PRICE_W - 32;
    localparam int PHI_W    = PHI_IN_W + LIMIT_W;
    localparam int HI_SHIFT = 32 - FRACTION_BITS;
    localparam int SUM_W    = VALUE_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536000);
    localparam logic [VALUE_W-1:0] VALUE_MAX   = {VALUE_W{1'b1}};

    // year / 25 by reciprocal, exact for every 14-bit year
    localparam int RECIP25_W     = 15;
    localparam int RECIP25_SHIFT = 19;
    localparam logic [RECIP25_W-1:0] RECIP25 = RECIP25_W'(20972);
    localparam int Q25_W         = YEAR_W + RECIP25_W - RECIP25_SHIFT;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_PRICE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 7'd12;
    localparam logic [4:0]         LEAP_FEB  = 5'd29;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DATE,
        S_SEARCH,
        S_FOUND,
        S_FETCH,
        S_INSERT,
        S_SHIFT,
        S_PLACE,
        S_MUL,
        S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_LO,
        SC_HI,
        SC_SUM
    } scale_state_t;

    typedef struct packed {
        logic              ok;
        logic [KEY_W-1:0]  key;
    } date_info_t;

    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [KEY_W-1:0]   wr_key;
        logic [PRICE_W-1:0] wr_price;
    } tbl_req_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } tbl_rsp_t;

    typedef struct packed {
        logic               start;
        logic [PRICE_W-1:0] price;
        logic [LIMIT_W-1:0] amount;
    } scale_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } scale_rsp_t;

    // days in a non-leap month, zero for codes that are no month
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dated_rate_floor_lookup.sv
// top level of the dated rate floor lookup: sequencer, table, checks and output register
// query: date check, binary search over the stored keys, fetch of the floor price, scaling
// load: date check, binary search, then entries above the slot move up, top first, and the new one is placed
// one item at a time; the single read port of the table memories sets the search pace
// reset clears the entry count, the sequencer and the output valid; limit returns to 1000.0
// no clearing pass: entries at or above the count are never read
`default_nettype none
`include "dated_rate_floor_lookup_macros.svh"

module dated_rate_floor_lookup (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [drfl_pkg::LIMIT_W-1:0]  cfg_wdata,
    // item channel
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic                          command,
    input  wire logic [drfl_pkg::YEAR_W-1:0]   date_year,
    input  wire logic [drfl_pkg::MONTH_W-1:0]  date_month,
    input  wire logic [drfl_pkg::DAY_W-1:0]    date_day,
    input  wire logic [drfl_pkg::PRICE_W-1:0]  entry_price,
    input  wire logic signed [drfl_pkg::AMOUNT_W-1:0] coin_amount,
    // result channel
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [drfl_pkg::STATUS_W-1:0]      status,
    output logic [drfl_pkg::VALUE_W-1:0]       converted_value
);
    import drfl_pkg::*;

    // sequencer state
    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [AMOUNT_W-1:0] amount_reg, amount_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [ADDR_W-1:0]   mid_reg, mid_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [LIMIT_W-1:0]  limit_reg;

    // output register
    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    logic                res_load;

    // submodule links
    logic                item_take;
    date_info_t          date_info;
    tbl_req_t            tbl_req;
    tbl_rsp_t            tbl_rsp;
    scale_req_t          scale_req;
    scale_rsp_t          scale_rsp;

    // search helpers
    logic                key_le;
    logic [CNT_W-1:0]    lo_step, hi_step;
    logic [CNT_W:0]      mid_sum;
    logic [CNT_W-1:0]    lo_dec;
    logic [CNT_W-1:0]    count_dec;

    assign item_stall = (state_reg != S_IDLE);
    assign item_take  = item_valid && !item_stall;

    drfl_date_check u_date (
        .clk   (clk),
        .load  (item_take),
        .year  (date_year),
        .month (date_month),
        .day   (date_day),
        .info  (date_info)
    );

    drfl_table u_table (
        .clk (clk),
        .req (tbl_req),
        .rsp (tbl_rsp)
    );

    drfl_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scale_req),
        .rsp   (scale_rsp)
    );

    // amount limit register: write only while idle; the block itself does not check this
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg    <= cmd_next;
        price_reg  <= price_next;
        amount_reg <= amount_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        if (res_load) begin
            res_status_reg <= status_reg;
            res_value_reg  <= value_reg;
        end
    end

    // one halving step per cycle: the key read at mid last cycle is compared now
    assign key_le    = (tbl_rsp.key <= date_info.key);
    assign lo_step   = key_le ? (CNT_W'(mid_reg) + CNT_W'(1)) : lo_reg;
    assign hi_step   = key_le ? hi_reg : CNT_W'(mid_reg);
    assign mid_sum   = (CNT_W+1)'(lo_step) + (CNT_W+1)'(hi_step);
    assign lo_dec    = lo_reg - CNT_W'(1);
    assign count_dec = entry_count_reg - CNT_W'(1);

    // result leaves for the output register once that register is free
    assign res_load       = (state_reg == S_RESULT) && (!res_valid_reg || !result_stall);
    assign res_valid_next = res_load || (res_valid_reg && result_stall);

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        price_next       = price_reg;
        amount_next      = amount_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        ptr_next         = ptr_reg;
        entry_count_next = entry_count_reg;
        status_next      = status_reg;
        value_next       = value_reg;
        tbl_req          = '0;
        scale_req        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    cmd_next    = command;
                    price_next  = entry_price;
                    amount_next = coin_amount;
                    status_next = ST_OK;
                    value_next  = '0;
                    state_next  = S_DATE;
                end
            end

            S_DATE: begin
                lo_next = '0;
                hi_next = entry_count_reg;
                if (!date_info.ok) begin
                    status_next = ST_BAD_DATE;
                    state_next  = S_RESULT;
                end else if (entry_count_reg != '0) begin
                    // first probe at the middle of the filled range
                    mid_next        = entry_count_reg[ADDR_W:1];
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = entry_count_reg[ADDR_W:1];
                    state_next      = S_SEARCH;
                end else begin
                    state_next = S_FOUND;
                end
            end

            S_SEARCH: begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step) begin
                    mid_next        = mid_sum[ADDR_W:1];
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = mid_sum[ADDR_W:1];
                end else begin
                    state_next = S_FOUND;
                end
            end

            // lo now counts the stored keys at or before the item's date
            S_FOUND: begin
                if (cmd_reg == CMD_QUERY) begin
                    if (amount_reg[AMOUNT_W-1]) begin
                        status_next = ST_NEGATIVE;
                        state_next  = S_RESULT;
                    end else if (amount_reg[LIMIT_W-1:0] > limit_reg) begin
                        status_next = ST_TOO_LARGE;
                        state_next  = S_RESULT;
                    end else if (lo_reg == '0) begin
                        status_next = ST_NO_PRICE;
                        state_next  = S_RESULT;
                    end else begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = lo_dec[ADDR_W-1:0];
                        state_next      = S_FETCH;
                    end
                end else if (lo_reg != '0) begin
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = lo_dec[ADDR_W-1:0];
                    state_next      = S_FETCH;
                end else begin
                    state_next = S_INSERT;
                end
            end

            S_FETCH: begin
                if (cmd_reg == CMD_QUERY) begin
                    scale_req.start  = 1'b1;
                    scale_req.price  = tbl_rsp.price;
                    scale_req.amount = amount_reg[LIMIT_W-1:0];
                    state_next       = S_MUL;
                end else if (tbl_rsp.key == date_info.key) begin
                    // repeated date: overwrite the price, even on a full table
                    tbl_req.wr_en    = 1'b1;
                    tbl_req.wr_addr  = lo_dec[ADDR_W-1:0];
                    tbl_req.wr_key   = date_info.key;
                    tbl_req.wr_price = price_reg;
                    state_next       = S_RESULT;
                end else begin
                    state_next = S_INSERT;
                end
            end

            S_INSERT: begin
                if (entry_count_reg == CNT_W'(TABLE_DEPTH)) begin
                    status_next = ST_FULL;
                    state_next  = S_RESULT;
                end else if (entry_count_reg > lo_reg) begin
                    // open a gap: move entries up, top first
                    ptr_next        = count_dec[ADDR_W-1:0];
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = count_dec[ADDR_W-1:0];
                    state_next      = S_SHIFT;
                end else begin
                    state_next = S_PLACE;
                end
            end

            // read ptr-1 while ptr's data goes to ptr+1: never the same entry
            S_SHIFT: begin
                tbl_req.wr_en    = 1'b1;
                tbl_req.wr_addr  = ptr_reg + ADDR_W'(1);
                tbl_req.wr_key   = tbl_rsp.key;
                tbl_req.wr_price = tbl_rsp.price;
                if (CNT_W'(ptr_reg) > lo_reg) begin
                    ptr_next        = ptr_reg - ADDR_W'(1);
                    tbl_req.rd_en   = 1'b1;
                    tbl_req.rd_addr = ptr_reg - ADDR_W'(1);
                end else begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE: begin
                tbl_req.wr_en    = 1'b1;
                tbl_req.wr_addr  = lo_reg[ADDR_W-1:0];
                tbl_req.wr_key   = date_info.key;
                tbl_req.wr_price = price_reg;
                entry_count_next = entry_count_reg + CNT_W'(1);
                state_next       = S_RESULT;
            end

            S_MUL: begin
                if (scale_rsp.done) begin
                    value_next = scale_rsp.value;
                    state_next = S_RESULT;
                end
            end

            S_RESULT: begin
                if (res_load) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign result_valid    = res_valid_reg;
    assign status          = res_status_reg;
    assign converted_value = res_value_reg;

    // the table never holds more entries than it has room for
    `DRFL_ASSERT_HOLDS(a_count_bound, 1'b1, entry_count_reg <= CNT_W'(TABLE_DEPTH), "entry count past depth")

    // the count moves by at most one entry per cycle
    `DRFL_ASSERT_NEXT(a_count_step, 1'b1, (entry_count_reg == $past(entry_count_reg) || entry_count_reg == $past(entry_count_reg) + CNT_W'(1)), "entry count jumped")

    // an outstanding probe always lies in a nonempty range inside the filled part
    `DRFL_ASSERT_HOLDS(a_search_range, state_reg == S_SEARCH, (lo_reg < hi_reg && hi_reg <= entry_count_reg), "search range broken")

    // a full report only comes from a full table
    `DRFL_ASSERT_HOLDS(a_full_status, res_load && status_reg == ST_FULL, entry_count_reg == CNT_W'(TABLE_DEPTH), "full status on table with room")

endmodule

`default_nettype wire

// File: rtl/drfl_date_check.sv
// calendar check of a date and packing of its sort key
`default_nettype none

module drfl_date_check (
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic [drfl_pkg::YEAR_W-1:0]  year,
    input  wire logic [drfl_pkg::MONTH_W-1:0] month,
    input  wire logic [drfl_pkg::DAY_W-1:0]   day,
    output drfl_pkg::date_info_t              info
);
    import drfl_pkg::*;

    logic [YEAR_W-1:0]                year_reg;
    logic [MONTH_W-1:0]               month_reg;
    logic [DAY_W-1:0]                 day_reg;
    logic [Q25_W-1:0]                 q25_reg;
    logic [YEAR_W+RECIP25_W-1:0]      recip_prod;
    logic [YEAR_W-1:0]                q25_times25;
    logic                             div25;
    logic                             leap;
    logic [4:0]                       len;
    logic                             month_ok;

    assign recip_prod = year * RECIP25;

    always_ff @(posedge clk) begin
        if (load) begin
            year_reg  <= year;
            month_reg <= month;
            day_reg   <= day;
            q25_reg   <= recip_prod[YEAR_W+RECIP25_W-1:RECIP25_SHIFT];
        end
    end

    // 25*q as shift-add
    assign q25_times25 = YEAR_W'({q25_reg, 4'b0}) + YEAR_W'({q25_reg, 3'b0})
                       + YEAR_W'(q25_reg);
    assign div25 = (q25_times25 == year_reg);

    // divisible by 400 is 25 and 16; by 100 is 25 and 4
    assign leap = div25 ? (year_reg[3:0] == 4'd0) : (year_reg[1:0] == 2'd0);

    assign month_ok = (month_reg != '0) && (month_reg <= MONTH_DEC);

    always_comb begin
        len = month_days(month_reg[3:0]);
        if (month_reg == MONTH_FEB && leap) begin
            len = LEAP_FEB;
        end
    end

    assign info.ok  = month_ok && (day_reg != '0) && (day_reg <= DAY_W'(len));
    assign info.key = {year_reg, month_reg[3:0], day_reg[4:0]};

endmodule

`default_nettype wire

// File: rtl/drfl_table.sv
// sorted key and price memories, one read and one write port each
`default_nettype none

module drfl_table (
    input  wire logic               clk,
    input  wire drfl_pkg::tbl_req_t req,
    output drfl_pkg::tbl_rsp_t      rsp
);
    import drfl_pkg::*;

    logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
    logic [PRICE_W-1:0] price_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   rd_key_reg;
    logic [PRICE_W-1:0] rd_price_reg;

    always_ff @(posedge clk) begin
        if (req.wr_en) begin
            key_mem[req.wr_addr]   <= req.wr_key;
            price_mem[req.wr_addr] <= req.wr_price;
        end
        if (req.rd_en) begin
            rd_key_reg   <= key_mem[req.rd_addr];
            rd_price_reg <= price_mem[req.rd_addr];
        end
    end

    assign rsp.key   = rd_key_reg;
    assign rsp.price = rd_price_reg;

endmodule

`default_nettype wire

// File: rtl/drfl_scale.sv
// price times amount over two partial products, truncated and saturated
`default_nettype none

module drfl_scale (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire drfl_pkg::scale_req_t req,
    output drfl_pkg::scale_rsp_t      rsp
);
    import drfl_pkg::*;

    scale_state_t       state_reg, state_next;
    logic [PRICE_W-1:0] price_reg;
    logic [LIMIT_W-1:0] amount_reg;
    logic [PLO_W-1:0]   plo_reg;
    logic [PHI_W-1:0]   phi_reg;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               done_reg, done_next;
    logic [SUM_W-1:0]   sum;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        if (req.start) begin
            price_reg  <= req.price;
            amount_reg <= req.amount;
        end
        if (state_reg == SC_LO) begin
            plo_reg <= price_reg[31:0] * amount_reg;
        end
        if (state_reg == SC_HI) begin
            phi_reg <= price_reg[PRICE_W-1:32] * amount_reg;
        end
        value_reg <= value_next;
    end

    assign sum = SUM_W'({phi_reg[VALUE_W-HI_SHIFT-1:0], {HI_SHIFT{1'b0}}})
               + SUM_W'(plo_reg[PLO_W-1:FRACTION_BITS]);

    always_comb begin
        state_next = state_reg;
        value_next = value_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            SC_IDLE: begin
                if (req.start) begin
                    state_next = SC_LO;
                end
            end
            SC_LO: state_next = SC_HI;
            SC_HI: state_next = SC_SUM;
            SC_SUM: begin
                // high bits past the result width saturate outright
                if (phi_reg[PHI_W-1:VALUE_W-HI_SHIFT] != '0 || sum[SUM_W-1]) begin
                    value_next = VALUE_MAX;
                end else begin
                    value_next = sum[VALUE_W-1:0];
                end
                done_next  = 1'b1;
                state_next = SC_IDLE;
            end
            default: state_next = SC_IDLE;
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

`default_nettype wire
